@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// implication property checked on every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// expression that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ rtl/core/rss_pkg.sv @@
// ----------------------------------------------------------------------------
// rss_pkg
// widths and beat types of the running signal statistics unit
// ----------------------------------------------------------------------------
package rss_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_BITS  = 24;
    localparam int MASK_BITS   = 6;
    localparam int STAT_BITS   = 16;
    localparam int VAR_BITS    = 32;

    // derived datapath widths
    localparam int SUM_W   = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_W    = 2 * SAMPLE_BITS + COUNT_BITS;
    localparam int NUM_W   = 2 * SAMPLE_BITS + 2 * COUNT_BITS;
    localparam int DEN_W   = 2 * COUNT_BITS;
    localparam int MAG_W   = SAMPLE_BITS + 1;
    localparam int ROOT_W  = (SQ_W + 1) / 2;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int ITER_W  = $clog2(NUM_W + 1);

    // enable mask bits
    localparam int EN_MAX    = 0;
    localparam int EN_MAXABS = 1;
    localparam int EN_MEAN   = 2;
    localparam int EN_MIN    = 3;
    localparam int EN_RMS    = 4;
    localparam int EN_VAR    = 5;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    typedef struct packed {
        logic                          func;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_in_beat;

    typedef struct packed {
        logic [COUNT_BITS-1:0]       sample_count;
        logic signed [STAT_BITS-1:0] max_value;
        logic signed [STAT_BITS-1:0] min_value;
        logic [STAT_BITS-1:0]        max_abs_value;
        logic signed [STAT_BITS-1:0] mean_value;
        logic [STAT_BITS-1:0]        rms_value;
        logic [VAR_BITS-1:0]         variance_value;
        logic                        overflow;
    } t_out_beat;

endpackage

@@ rtl/core/running_signal_statistics_unit.sv @@
// ----------------------------------------------------------------------------
// running_signal_statistics_unit
// running count, max, min, max-abs, mean, rms and unbiased variance
// ----------------------------------------------------------------------------
// Each input beat either inserts a signed Q8.8 sample or clears all
// accumulators, and produces one snapshot beat of the enabled statistics.
// An inserted sample goes from acceptance to its result through an
// update state, a setup state, 24 shift-add steps for n*sumsq and
// n*(n-1), 40 steps subtracting sum^2, then one restoring divider
// running 40 steps for the mean, 56 for sumsq/n and 80 for the variance,
// with a 28-step square root between, and a hand-off state. With fewer
// than two samples the variance division is skipped. A clear, or an
// empty count, goes from the setup state straight to the hand-off. The
// input is ready only while the sequencer is idle, so no new beat is
// taken while a sample is being worked on; a finished snapshot waits in
// the output register and does not block it.
`include "assert_macros.svh"

module running_signal_statistics_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rss_pkg::MASK_BITS-1:0] i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  rss_pkg::t_in_beat           i_in_beat,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output rss_pkg::t_out_beat          o_out_beat
);
    import rss_pkg::*;

    // sequencer states
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_UPD   = 4'd1;
    localparam logic [3:0] ST_PREP  = 4'd2;
    localparam logic [3:0] ST_MUL   = 4'd3;
    localparam logic [3:0] ST_SQR   = 4'd4;
    localparam logic [3:0] ST_DMEAN = 4'd5;
    localparam logic [3:0] ST_DRMS  = 4'd6;
    localparam logic [3:0] ST_SQRT  = 4'd7;
    localparam logic [3:0] ST_DVAR  = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    localparam logic [COUNT_BITS-1:0] COUNT_FULL = {COUNT_BITS{1'b1}};

    logic [3:0]                 r_state;
    logic [MASK_BITS-1:0]       r_mask;
    logic                       r_func;
    logic [SAMPLE_BITS-1:0]     r_smp;

    // accumulators
    logic [COUNT_BITS-1:0]      r_count;
    logic [SAMPLE_BITS-1:0]     r_max;
    logic [SAMPLE_BITS-1:0]     r_min;
    logic [MAG_W-1:0]           r_max_abs;
    logic [SUM_W-1:0]           r_sum;
    logic [SQ_W-1:0]            r_sumsq;
    logic                       r_dropped;

    // shared shift-add multiplier
    logic [NUM_W-1:0]           r_acc;
    logic [NUM_W-1:0]           r_mc;
    logic [SUM_W-1:0]           r_mp;
    logic [DEN_W-1:0]           r_den;
    logic [DEN_W-1:0]           r_dc;

    // shared restoring divider
    logic [NUM_W-1:0]           r_quo;
    logic [DEN_W-1:0]           r_rem;
    logic [DEN_W-1:0]           r_div;
    logic [ITER_W-1:0]          r_iter;

    // square root
    logic [RAD_W-1:0]           r_rad;
    logic [ROOT_W-1:0]          r_root;
    logic [ROOT_W+1:0]          r_srem;

    // results
    logic [STAT_BITS-1:0]       r_mean;
    logic [STAT_BITS-1:0]       r_rms;
    logic [VAR_BITS-1:0]        r_var;
    logic                       r_ovalid;
    t_out_beat                  r_out;

    // combinational helpers
    logic [MAG_W-1:0]           w_sext;
    logic [MAG_W-1:0]           w_mag;
    logic [2*MAG_W-1:0]         w_sq;
    logic [SUM_W-1:0]           w_smag;
    logic [DEN_W:0]             w_dt;
    logic [DEN_W:0]             w_dsub;
    logic                       w_dge;
    logic [DEN_W-1:0]           w_rem_nx;
    logic [NUM_W-1:0]           w_quo_nx;
    logic [SUM_W-1:0]           w_mean_q;
    logic [SUM_W-1:0]           w_mean_s;
    logic [ROOT_W+1:0]          w_st;
    logic [ROOT_W+1:0]          w_trial;
    logic                       w_sge;
    logic [ROOT_W+1:0]          w_srem_nx;
    logic [ROOT_W-1:0]          w_root_nx;
    logic                       w_last;
    logic                       w_in_acc;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_beat  = r_out;
    assign w_last      = (r_iter == ITER_W'(1));

    always_comb begin
        // sample magnitude, one bit wider so the most negative value fits
        w_sext = {r_smp[SAMPLE_BITS-1], r_smp};
        w_mag  = w_sext[MAG_W-1] ? (~w_sext + MAG_W'(1)) : w_sext;
        w_sq   = w_mag * w_mag;
        w_smag = r_sum[SUM_W-1] ? (~r_sum + SUM_W'(1)) : r_sum;

        // one divider step
        w_dt     = {r_rem, r_quo[NUM_W-1]};
        w_dsub   = w_dt - {1'b0, r_div};
        w_dge    = (w_dt >= {1'b0, r_div});
        w_rem_nx = w_dge ? w_dsub[DEN_W-1:0] : w_dt[DEN_W-1:0];
        w_quo_nx = {r_quo[NUM_W-2:0], w_dge};

        // mean is signed by the sum, truncated toward zero
        w_mean_q = w_quo_nx[SUM_W-1:0];
        w_mean_s = r_sum[SUM_W-1] ? (~w_mean_q + SUM_W'(1)) : w_mean_q;

        // one square root digit
        w_st      = {r_srem[ROOT_W-1:0], r_rad[RAD_W-1:RAD_W-2]};
        w_trial   = {r_root, 2'b01};
        w_sge     = (w_st >= w_trial);
        w_srem_nx = w_sge ? (w_st - w_trial) : w_st;
        w_root_nx = {r_root[ROOT_W-2:0], w_sge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_mask    <= {MASK_BITS{1'b1}};
            r_ovalid  <= 1'b0;
            r_count   <= '0;
            r_max     <= '0;
            r_min     <= '0;
            r_max_abs <= '0;
            r_sum     <= '0;
            r_sumsq   <= '0;
            r_dropped <= 1'b0;
            r_iter    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
            // output register drains independently of the sequencer
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_func  <= i_in_beat.func;
                        r_smp   <= i_in_beat.sample;
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (r_func == FUNC_CLEAR) begin
                        r_count   <= '0;
                        r_max     <= '0;
                        r_min     <= '0;
                        r_max_abs <= '0;
                        r_sum     <= '0;
                        r_sumsq   <= '0;
                        r_dropped <= 1'b0;
                    end else if (r_count == COUNT_FULL) begin
                        r_dropped <= 1'b1;
                    end else begin
                        if (r_count == '0 || $signed(r_smp) > $signed(r_max)) begin
                            r_max <= r_smp;
                        end
                        if (r_count == '0 || $signed(r_smp) < $signed(r_min)) begin
                            r_min <= r_smp;
                        end
                        if (w_mag > r_max_abs) begin
                            r_max_abs <= w_mag;
                        end
                        r_sum   <= r_sum + {{COUNT_BITS{r_smp[SAMPLE_BITS-1]}}, r_smp};
                        r_sumsq <= r_sumsq + SQ_W'(w_sq);
                        r_count <= r_count + COUNT_BITS'(1);
                    end
                    r_state <= ST_PREP;
                end
                ST_PREP: begin
                    r_mean <= '0;
                    r_rms  <= '0;
                    r_var  <= '0;
                    if (r_count == '0) begin
                        r_state <= ST_DONE;
                    end else begin
                        // n*sumsq and n*(n-1) side by side
                        r_acc   <= '0;
                        r_den   <= '0;
                        r_mc    <= NUM_W'(r_sumsq);
                        r_dc    <= DEN_W'(r_count - COUNT_BITS'(1));
                        r_mp    <= SUM_W'(r_count);
                        r_iter  <= ITER_W'(COUNT_BITS);
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (r_mp[0]) begin
                        r_acc <= r_acc + r_mc;
                        r_den <= r_den + r_dc;
                    end
                    r_mc   <= {r_mc[NUM_W-2:0], 1'b0};
                    r_dc   <= {r_dc[DEN_W-2:0], 1'b0};
                    r_mp   <= {1'b0, r_mp[SUM_W-1:1]};
                    r_iter <= r_iter - ITER_W'(1);
                    if (w_last) begin
                        // next: subtract sum^2
                        r_mc    <= NUM_W'(w_smag);
                        r_mp    <= w_smag;
                        r_iter  <= ITER_W'(SUM_W);
                        r_state <= ST_SQR;
                    end
                end
                ST_SQR: begin
                    if (r_mp[0]) begin
                        r_acc <= r_acc - r_mc;
                    end
                    r_mc   <= {r_mc[NUM_W-2:0], 1'b0};
                    r_mp   <= {1'b0, r_mp[SUM_W-1:1]};
                    r_iter <= r_iter - ITER_W'(1);
                    if (w_last) begin
                        r_quo   <= NUM_W'(w_smag) << (NUM_W - SUM_W);
                        r_rem   <= '0;
                        r_div   <= DEN_W'(r_count);
                        r_iter  <= ITER_W'(SUM_W);
                        r_state <= ST_DMEAN;
                    end
                end
                ST_DMEAN: begin
                    r_quo  <= w_quo_nx;
                    r_rem  <= w_rem_nx;
                    r_iter <= r_iter - ITER_W'(1);
                    if (w_last) begin
                        r_mean  <= w_mean_s[STAT_BITS-1:0];
                        r_quo   <= NUM_W'(r_sumsq) << (NUM_W - SQ_W);
                        r_rem   <= '0;
                        r_iter  <= ITER_W'(SQ_W);
                        r_state <= ST_DRMS;
                    end
                end
                ST_DRMS: begin
                    r_quo  <= w_quo_nx;
                    r_rem  <= w_rem_nx;
                    r_iter <= r_iter - ITER_W'(1);
                    if (w_last) begin
                        r_rad   <= RAD_W'(w_quo_nx[SQ_W-1:0]);
                        r_root  <= '0;
                        r_srem  <= '0;
                        r_iter  <= ITER_W'(ROOT_W);
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
                    r_root <= w_root_nx;
                    r_srem <= w_srem_nx;
                    r_iter <= r_iter - ITER_W'(1);
                    if (w_last) begin
                        // saturate to the 16-bit field
                        r_rms <= (|w_root_nx[ROOT_W-1:STAT_BITS]) ? {STAT_BITS{1'b1}}
                                                                  : w_root_nx[STAT_BITS-1:0];
                        if (r_count >= COUNT_BITS'(2)) begin
                            r_quo   <= r_acc;
                            r_rem   <= '0;
                            r_div   <= r_den;
                            r_iter  <= ITER_W'(NUM_W);
                            r_state <= ST_DVAR;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_DVAR: begin
                    r_quo  <= w_quo_nx;
                    r_rem  <= w_rem_nx;
                    r_iter <= r_iter - ITER_W'(1);
                    if (w_last) begin
                        r_var   <= (|w_quo_nx[NUM_W-1:VAR_BITS]) ? {VAR_BITS{1'b1}}
                                                                 : w_quo_nx[VAR_BITS-1:0];
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    // hand the snapshot over once the output register is free
                    if (!r_ovalid || i_out_ready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // snapshot, masked by the enables
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && (!r_ovalid || i_out_ready)) begin
            r_out.sample_count   <= r_count;
            r_out.max_value      <= r_mask[EN_MAX] ? r_max[STAT_BITS-1:0] : '0;
            r_out.min_value      <= r_mask[EN_MIN] ? r_min[STAT_BITS-1:0] : '0;
            r_out.max_abs_value  <= r_mask[EN_MAXABS] ? r_max_abs[STAT_BITS-1:0] : '0;
            r_out.mean_value     <= r_mask[EN_MEAN] ? r_mean : '0;
            r_out.rms_value      <= r_mask[EN_RMS] ? r_rms : '0;
            r_out.variance_value <= r_mask[EN_VAR] ? r_var : '0;
            r_out.overflow       <= r_dropped;
        end
    end

    // an accepted beat always starts with the update cycle
    `ASSERT_PROP(a_acc_upd, i_clk, i_rst_n, w_in_acc |=> (r_state == ST_UPD))
    // accumulators only move in the update cycle
    `ASSERT_PROP(a_cnt_hold, i_clk, i_rst_n, (r_state != ST_UPD) |=> $stable(r_count))
    // a finished snapshot always lands in the output register
    `ASSERT_PROP(a_done_out, i_clk, i_rst_n,
        (r_state == ST_DONE && (!r_ovalid || i_out_ready)) |=> r_ovalid)
    // the dropped flag only rises on a sample seen with the count full
    `ASSERT_NEVER(a_no_drop_inc, i_clk, i_rst_n,
        r_dropped && !$past(r_dropped) && ($past(r_count) != COUNT_FULL))

endmodule
